### hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned OccW   = 5;

  typedef enum logic [0:0] {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic        [PrioW-1:0]  prio;
  } entry_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] value;
    logic        [PrioW-1:0]  prio;
    logic        [OccW-1:0]   occ;
  } result_t;

endpackage

### hdl/spq_req_if.sv
// Request channel: enqueue or dequeue operations with valid/ready.
interface spq_req_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  action_e                  action;
  logic signed [ValueW-1:0] item_value;
  logic        [PrioW-1:0]  item_priority;

  modport source (output valid, output action, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input action, input item_value, input item_priority,
                  output ready);
endinterface

### hdl/spq_rsp_if.sv
// Response channel: one status word per operation with valid/ready.
interface spq_rsp_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  status_e                  status;
  logic signed [ValueW-1:0] out_value;
  logic        [PrioW-1:0]  out_priority;
  logic        [OccW-1:0]   occupancy;

  modport source (output valid, output status, output out_value, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_value, input out_priority,
                  input occupancy, output ready);
endinterface

### hdl/sorted_priority_queue_core.sv
// Sorted priority queue: entries held in order in one synchronous RAM used as a ring.
//
// req_i carries operations: enqueue (value, priority) or dequeue the head.
// rsp_o returns one transfer per operation: status, dequeued value and
// priority (zero unless a dequeue succeeded) and occupancy after the operation.
// Entries are kept sorted by priority, highest first, equal priorities in
// arrival order. The RAM has one read and one write port and a registered read.
// Operations are handled one at a time. Full enqueue, empty dequeue and
// enqueue into an empty queue finish in S_IDLE; a dequeue reads the head and
// finishes in S_DEQ. An enqueue into a queue of N entries walks back from the
// tail in S_INS, moving each entry of lower priority one slot toward the tail
// (one RAM read and one RAM write per cycle), and ends in S_INS or, after
// passing the head, in S_HEAD. Each result goes through the holding register
// and then the output register to rsp_o.
// A finished result parks in a holding register while the output register
// waits on a stalled receiver, so one further result can be computed;
// req_i.ready drops while the holding register is occupied.
// Reset empties the queue at once; RAM contents need no clearing since only
// occupied slots are ever read.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);
  import spq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_HEAD,
    S_DEQ
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  base_q, base_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  idx_q, idx_d;
  entry_t         new_q, new_d;
  result_t        res_q, res_d;
  logic           res_valid_q, res_valid_d;
  result_t        out_q, out_d;
  logic           out_valid_q, out_valid_d;

  entry_t         mem_q [DEPTH];
  entry_t         rd_q;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  entry_t         wr_data;

  logic           req_xfer;
  logic           out_free;
  logic           fin;
  result_t        fin_res;

  // Logical slot to physical RAM address in the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base_q} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign req_i.ready = (state_q == S_IDLE) && !res_valid_q;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.out_value    = out_q.value;
  assign rsp_o.out_priority = out_q.prio;
  assign rsp_o.occupancy    = out_q.occ;

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    count_d = count_q;
    idx_d   = idx_q;
    new_d   = new_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_q;
    fin     = 1'b0;
    fin_res = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          new_d = '{value: req_i.item_value, prio: req_i.item_priority};
          if (req_i.action == ACT_ENQ) begin
            if (count_q == CW'(DEPTH)) begin
              fin            = 1'b1;
              fin_res.status = ST_FULL;
            end else if (count_q == '0) begin
              wr_en          = 1'b1;
              wr_addr        = phys('0);
              wr_data        = '{value: req_i.item_value, prio: req_i.item_priority};
              count_d        = count_q + CW'(1);
              fin            = 1'b1;
              fin_res.status = ST_OK;
            end else begin
              // walk back from the tail
              idx_d   = AW'(count_q - CW'(1));
              rd_en   = 1'b1;
              rd_addr = phys(AW'(count_q - CW'(1)));
              state_d = S_INS;
            end
          end else begin
            if (count_q == '0) begin
              fin            = 1'b1;
              fin_res.status = ST_EMPTY;
            end else begin
              rd_en   = 1'b1;
              rd_addr = base_q;
              state_d = S_DEQ;
            end
          end
        end
      end
      S_INS: begin
        // Write goes to idx+1 while the read targets idx-1: never the same slot.
        wr_en   = 1'b1;
        wr_addr = phys(idx_q + AW'(1));
        if (rd_q.prio >= new_q.prio) begin
          wr_data        = new_q;
          count_d        = count_q + CW'(1);
          fin            = 1'b1;
          fin_res.status = ST_OK;
          state_d        = S_IDLE;
        end else begin
          wr_data = rd_q;
          if (idx_q == '0) begin
            state_d = S_HEAD;
          end else begin
            idx_d   = idx_q - AW'(1);
            rd_en   = 1'b1;
            rd_addr = phys(idx_q - AW'(1));
          end
        end
      end
      S_HEAD: begin
        wr_en          = 1'b1;
        wr_addr        = phys('0);
        wr_data        = new_q;
        count_d        = count_q + CW'(1);
        fin            = 1'b1;
        fin_res.status = ST_OK;
        state_d        = S_IDLE;
      end
      S_DEQ: begin
        base_d         = phys(AW'(1));
        count_d        = count_q - CW'(1);
        fin            = 1'b1;
        fin_res.status = ST_OK;
        fin_res.value  = rd_q.value;
        fin_res.prio   = rd_q.prio;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    fin_res.occ = OccW'(count_d);
  end

  // Holding register feeds the output register.
  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid_q && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      res_valid_d = 1'b0;
    end else if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fin) begin
      res_d       = fin_res;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above capacity");

  a_ins_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> ({1'b0, idx_q} < (AW+1)'(count_q)))
    else $error("insertion walk outside occupied slots");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && req_i.action == ACT_ENQ && count_q == CW'(DEPTH)) |=> $stable(count_q))
    else $error("dropped enqueue changed occupancy");

  a_park_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_valid_q && !rsp_o.ready) |=> (res_valid_q && $stable(res_q)))
    else $error("parked result lost while output stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !res_valid_q)
    else $error("operation in progress with a parked result");

endmodule
